// File: sv/bssm_pkg.sv
// Shared types, constants and the seven-segment encoder for the display driver.
package bssm_pkg;

	localparam int SampleWidth = 10;
	localparam int DigitCount  = 4;
	localparam int SegWidth    = 8;
	localparam int DigitIdxW   = $clog2(DigitCount);

	typedef logic [SampleWidth-1:0] sample_t;
	typedef logic [3:0]             bcd_t;
	typedef logic [SegWidth-1:0]    seg_t;
	typedef logic [DigitIdxW-1:0]   digit_idx_t;
	typedef logic [DigitCount-1:0]  digit_sel_t;

	// Common-anode patterns: a low bit lights the segment, the point stays dark.
	localparam seg_t SegBlank = 8'hFF;

	function automatic seg_t seg_encode(input bcd_t d);
		seg_t s;
		unique case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = SegBlank;
		endcase
		return s;
	endfunction

endpackage

// File: sv/bssm_digit_pipe.sv
// Four-stage pipeline that splits a reading into decimal digits and encodes segments.
module bssm_digit_pipe import bssm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  sample_t sample,
	output logic    pipe_valid,
	input  logic    pipe_take,
	output seg_t    pipe_seg [DigitCount]
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	logic    thou_s1;
	sample_t rem_s1;
	logic    thou_s2;
	bcd_t    hund_s2;
	logic [6:0] rem_s2;
	logic    thou_s3;
	bcd_t    hund_s3, tens_s3, unit_s3;
	seg_t    seg_s4 [DigitCount];

	// A stage loads when it is empty or when its content moves on.
	assign en_s4 = !v_s4 || pipe_take;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// Thousands digit: a 10-bit reading holds at most one thousand.
	logic    thou_d;
	sample_t rem_d1;
	always_comb begin
		thou_d = (sample >= SampleWidth'(1000));
		rem_d1 = thou_d ? sample_t'(sample - SampleWidth'(1000)) : sample;
	end

	// Hundreds digit by comparing the remainder against each multiple of one hundred.
	bcd_t       hund_d;
	logic [6:0] rem_d2;
	always_comb begin
		hund_d = '0;
		rem_d2 = rem_s1[6:0];
		for (int k = 1; k < 10; k++) begin
			if (rem_s1 >= SampleWidth'(k * 100)) begin
				hund_d = 4'(k);
				rem_d2 = 7'(rem_s1 - SampleWidth'(k * 100));
			end
		end
	end

	// Tens and units from a remainder below one hundred.
	bcd_t tens_d, unit_d;
	always_comb begin
		tens_d = '0;
		unit_d = 4'(rem_s2);
		for (int k = 1; k < 10; k++) begin
			if (rem_s2 >= 7'(k * 10)) begin
				tens_d = 4'(k);
				unit_d = 4'(rem_s2 - 7'(k * 10));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			thou_s1 <= thou_d;
			rem_s1  <= rem_d1;
		end
		if (en_s2) begin
			thou_s2 <= thou_s1;
			hund_s2 <= hund_d;
			rem_s2  <= rem_d2;
		end
		if (en_s3) begin
			thou_s3 <= thou_s2;
			hund_s3 <= hund_s2;
			tens_s3 <= tens_d;
			unit_s3 <= unit_d;
		end
		if (en_s4) begin
			seg_s4[0] <= seg_encode({3'b000, thou_s3});
			seg_s4[1] <= seg_encode(hund_s3);
			seg_s4[2] <= seg_encode(tens_s3);
			seg_s4[3] <= seg_encode(unit_s3);
		end
	end

	assign pipe_valid = v_s4;
	assign pipe_seg   = seg_s4;

endmodule

// File: sv/bssm_serializer.sv
// Output register sending an item's four digit words one per unstalled cycle.
module bssm_serializer import bssm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pipe_valid,
	output logic       pipe_take,
	input  seg_t       pipe_seg [DigitCount],
	output logic       out_valid,
	input  logic       out_stall,
	output seg_t       segments,
	output digit_sel_t digit_select,
	output logic       last
);

	localparam digit_idx_t LastIdx = digit_idx_t'(DigitCount - 1);

	logic       busy_q;
	digit_idx_t idx_q;
	seg_t       seg_q [DigitCount];
	logic       fire;

	assign fire      = busy_q && !out_stall;
	assign pipe_take = !busy_q || (fire && idx_q == LastIdx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pipe_take) begin
			busy_q <= pipe_valid;
			idx_q  <= '0;
		end else if (fire) begin
			idx_q <= idx_q + digit_idx_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_take && pipe_valid) seg_q <= pipe_seg;
	end

	assign out_valid    = busy_q;
	assign segments     = seg_q[idx_q];
	assign digit_select = digit_sel_t'(1) << idx_q;
	assign last         = (idx_q == LastIdx);

endmodule

// File: sv/bcd_seven_segment_mux_driver_unit.sv
// Top level of the four-digit seven-segment display driver.
// Each accepted item is a 10-bit reading; the block answers with four digit words,
// thousands first and units last, each carrying an active-low common-anode segment
// byte (decimal point dark), a one-hot digit select and a last flag on the units
// word. Leading zeros are shown. An item runs through four pipeline stages
// (thousands split, hundreds split, tens and units split, segment encoding) and
// then into the output register. The output register sends one word per cycle
// while out_stall is low, which sets the sustained item rate; the pipeline keeps
// taking items while words wait, until its stages are all full.
module bcd_seven_segment_mux_driver_unit import bssm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  sample_t    sample,
	output logic       out_valid,
	input  logic       out_stall,
	output seg_t       segments,
	output digit_sel_t digit_select,
	output logic       last
);

	// Handshake between the digit pipeline and the word serializer.
	logic pipe_valid;
	logic pipe_take;
	seg_t pipe_seg [DigitCount];

	// Splits the reading into digits and encodes each digit into its segment byte.
	bssm_digit_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.pipe_valid (pipe_valid),
		.pipe_take  (pipe_take),
		.pipe_seg   (pipe_seg)
	);

	// Holds the four bytes and presents them in order, one word per accepted cycle.
	bssm_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.pipe_valid   (pipe_valid),
		.pipe_take    (pipe_take),
		.pipe_seg     (pipe_seg),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.segments     (segments),
		.digit_select (digit_select),
		.last         (last)
	);

endmodule

// File: sv/bssm_checker.sv
// Port-level checks for the display driver and their binding to the top level.
module bssm_checker import bssm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input seg_t       segments,
	input digit_sel_t digit_select,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(segments)
			&& $stable(digit_select) && $stable(last))
		else $error("stalled output word changed");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(digit_select))
		else $error("digit select is not one-hot");

	a_last_units: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == digit_select[DigitCount-1]))
		else $error("last flag does not mark the units word");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid
			&& digit_select == ($past(digit_select) << 1))
		else $error("digit words of one item did not follow in order");

	a_point_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> segments[SegWidth-1])
		else $error("decimal point lit");

endmodule

bind bcd_seven_segment_mux_driver_unit bssm_checker u_bssm_checker (.*);
